### src/midpoint_circle_generator_defines.svh
// assertion helpers shared by the circle generator modules
`ifndef MIDPOINT_CIRCLE_GENERATOR_DEFINES_SVH
`define MIDPOINT_CIRCLE_GENERATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MCG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MCG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mcg_pkg.sv
package mcg_pkg;

    // opcode values carried on the input tuser
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // decision parameter constants
    localparam int DEC_INIT     = 3;
    localparam int DEC_STEP_E   = 6;
    localparam int DEC_STEP_SE  = 10;

    // extra decision bits beyond the coordinate width
    localparam int DEC_EXTRA    = 5;

    // last pixel index of a point set
    localparam logic [2:0] IDX_LAST_FULL = 3'd7;
    localparam logic [2:0] IDX_LAST_HALF = 3'd3;

    // per-set control carried through the queue
    typedef struct packed {
        logic half;
        logic last;
    } t_job_ctl;

endpackage

### src/mcg_front.sv
`include "midpoint_circle_generator_defines.svh"

module mcg_front
    import mcg_pkg::*;
#(
    parameter int COORD_BITS = 11
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic                         i_opcode,
    input  logic signed [COORD_BITS-1:0] i_center_x,
    input  logic signed [COORD_BITS-1:0] i_center_y,
    input  logic        [COORD_BITS-2:0] i_radius,
    input  logic                         i_half_mode,
    output logic                         o_push,
    output logic signed [COORD_BITS-1:0] o_cx,
    output logic signed [COORD_BITS-1:0] o_cy,
    output logic signed [COORD_BITS-1:0] o_x,
    output logic signed [COORD_BITS-1:0] o_y,
    output t_job_ctl                     o_ctl
);

    localparam int DW = COORD_BITS + DEC_EXTRA;

    logic                         r_active;
    logic signed [COORD_BITS-1:0] r_x, r_y, r_cx, r_cy;
    logic signed [DW-1:0]         r_d;
    logic                         r_half;

    logic                         w_start;
    logic signed [COORD_BITS-1:0] w_cur_x, w_cur_y, w_cx, w_cy;
    logic signed [DW-1:0]         w_cur_d, w_r_ext;
    logic                         w_half;
    logic signed [COORD_BITS-1:0] n_x, n_y;
    logic signed [DW-1:0]         n_d;
    logic                         n_active;

    assign w_start = (i_opcode == OP_START);
    assign w_r_ext = DW'(signed'({1'b0, i_radius}));

    always_comb begin
        w_cur_x = w_start ? '0 : r_x;
        w_cur_y = w_start ? COORD_BITS'(signed'({1'b0, i_radius})) : r_y;
        w_cur_d = w_start ? (DW'(DEC_INIT) - (w_r_ext <<< 1)) : r_d;
        w_cx    = w_start ? i_center_x : r_cx;
        w_cy    = w_start ? i_center_y : r_cy;
        w_half  = w_start ? i_half_mode : r_half;
        n_x     = w_cur_x + COORD_BITS'(1);
        if (w_cur_d[DW-1]) begin
            n_y = w_cur_y;
            n_d = w_cur_d + (DW'(n_x) <<< 2) + DW'(DEC_STEP_E);
        end else begin
            n_y = w_cur_y - COORD_BITS'(1);
            n_d = w_cur_d + ((DW'(n_x) - DW'(n_y)) <<< 2) + DW'(DEC_STEP_SE);
        end
        n_active = (n_x <= n_y);
    end

    // an advance with no circle running produces no set
    assign o_push    = i_accept && (w_start || r_active);
    assign o_cx      = w_cx;
    assign o_cy      = w_cy;
    assign o_x       = w_cur_x;
    assign o_y       = w_cur_y;
    assign o_ctl     = '{half: w_half, last: !n_active};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_x      <= '0;
            r_y      <= '0;
            r_d      <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_half   <= 1'b0;
        end else if (o_push) begin
            r_active <= n_active;
            r_x      <= n_x;
            r_y      <= n_y;
            r_d      <= n_d;
            r_cx     <= w_cx;
            r_cy     <= w_cy;
            r_half   <= w_half;
        end
    end

    `MCG_ASSERT_NOW(a_active_in_octant, r_active, r_x <= r_y, "active circle left its octant")
    `MCG_ASSERT_NEXT(a_last_ends_run, o_push && o_ctl.last, !r_active,
        "circle still active after its last set")

endmodule

### src/mcg_queue.sv
`include "midpoint_circle_generator_defines.svh"

module mcg_queue
    import mcg_pkg::*;
#(
    parameter int COORD_BITS = 11
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    input  t_job_ctl                     i_ctl,
    input  logic                         i_pop,
    output logic                         o_full,
    output logic                         o_valid,
    output logic signed [COORD_BITS-1:0] o_cx,
    output logic signed [COORD_BITS-1:0] o_cy,
    output logic signed [COORD_BITS-1:0] o_x,
    output logic signed [COORD_BITS-1:0] o_y,
    output t_job_ctl                     o_ctl
);

    // two-entry queue of point sets
    logic signed [COORD_BITS-1:0] r_cx [2];
    logic signed [COORD_BITS-1:0] r_cy [2];
    logic signed [COORD_BITS-1:0] r_x  [2];
    logic signed [COORD_BITS-1:0] r_y  [2];
    t_job_ctl                     r_ctl[2];
    logic                         r_wr_ptr, r_rd_ptr;
    logic [1:0]                   r_count;
    logic                         w_do_pop;

    assign o_full   = (r_count == 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign w_do_pop = i_pop && o_valid;

    assign o_cx  = r_cx[r_rd_ptr];
    assign o_cy  = r_cy[r_rd_ptr];
    assign o_x   = r_x[r_rd_ptr];
    assign o_y   = r_y[r_rd_ptr];
    assign o_ctl = r_ctl[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_cx[r_wr_ptr]  <= i_cx;
            r_cy[r_wr_ptr]  <= i_cy;
            r_x[r_wr_ptr]   <= i_x;
            r_y[r_wr_ptr]   <= i_y;
            r_ctl[r_wr_ptr] <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push)   r_wr_ptr <= !r_wr_ptr;
            if (w_do_pop) r_rd_ptr <= !r_rd_ptr;
            r_count <= r_count + 2'(i_push) - 2'(w_do_pop);
        end
    end

    `MCG_ASSERT_NOW(a_no_overflow, i_push, !o_full, "push into full queue")
    `MCG_ASSERT_NOW(a_count_range, 1'b1, r_count <= 2'd2, "queue count out of range")

endmodule

### src/mcg_back.sv
`include "midpoint_circle_generator_defines.svh"

module mcg_back
    import mcg_pkg::*;
#(
    parameter int COORD_BITS = 11
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    input  t_job_ctl                     i_ctl,
    output logic                         o_pop,
    input  logic                         i_tready,
    output logic                         o_tvalid,
    output logic signed [COORD_BITS:0]   o_pixel_x,
    output logic signed [COORD_BITS:0]   o_pixel_y,
    output logic                         o_set_end,
    output logic                         o_circle_end
);

    localparam int PW = COORD_BITS + 1;

    logic [2:0]           r_idx;
    logic                 r_tvalid;
    logic signed [PW-1:0] r_px, r_py;
    logic                 r_set_end, r_circle_end;

    logic                 w_load, w_last_idx;
    logic [2:0]           w_full_idx;
    logic signed [PW-1:0] w_cx, w_cy, w_h, w_v, n_px, n_py;

    // half mode walks the odd entries of the full order
    assign w_full_idx = i_ctl.half ? {r_idx[1:0], 1'b1} : r_idx;
    assign w_last_idx = (r_idx == (i_ctl.half ? IDX_LAST_HALF : IDX_LAST_FULL));
    assign w_load     = i_valid && (!r_tvalid || i_tready);
    assign o_pop      = w_load && w_last_idx;

    always_comb begin
        w_cx = PW'(i_cx);
        w_cy = PW'(i_cy);
        // upper half of the set swaps the roles of x and y
        w_h  = w_full_idx[2] ? PW'(i_y) : PW'(i_x);
        w_v  = w_full_idx[2] ? PW'(i_x) : PW'(i_y);
        n_px = w_full_idx[1] ? (w_cx - w_h) : (w_cx + w_h);
        n_py = w_full_idx[0] ? (w_cy - w_v) : (w_cy + w_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_tvalid <= 1'b0;
        end else begin
            if (w_load) begin
                r_idx <= w_last_idx ? 3'd0 : r_idx + 3'd1;
            end
            if (w_load) begin
                r_tvalid <= 1'b1;
            end else if (i_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_px         <= n_px;
            r_py         <= n_py;
            r_set_end    <= w_last_idx;
            r_circle_end <= w_last_idx && i_ctl.last;
        end
    end

    assign o_tvalid     = r_tvalid;
    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_set_end    = r_set_end;
    assign o_circle_end = r_circle_end;

    `MCG_ASSERT_NOW(a_circle_end_on_set_end, r_tvalid && r_circle_end, r_set_end,
        "circle end without set end")
    `MCG_ASSERT_NOW(a_half_idx_range, i_valid && i_ctl.half, !r_idx[2],
        "half-mode pixel index out of range")

endmodule

### src/midpoint_circle_generator.sv
// midpoint circle generator: rasterizes circles with the integer decision-parameter
// method, one pixel per transaction on the output stream.
// input stream: tuser is the opcode (start or advance); tdata carries, from bit 0,
// center_x, center_y, radius, half_mode. a start loads a circle and emits its first
// point set; each advance emits the set for the current step. an advance with no
// circle running is accepted and produces nothing.
// output stream: tdata carries pixel_x then pixel_y; tlast marks the last pixel of
// a set; tuser marks the last pixel of the whole circle.
// throughput: a set is 8 pixels in full mode, 4 in lower-half mode, one pixel per
// cycle while the receiver is ready. the input side takes one item per cycle while
// the two-entry set queue has room.
// item path: with the pixel unit idle, an accepted set enters the queue on the
// accepting edge; the pixel unit then loads its first pixel from the queue into
// the output register, where it becomes valid.
// the front updates x, y and the decision term in the same cycle it pushes a set.
// reset (synchronous, active low) drops any running circle, empties the queue and
// clears the output valid flag. a stalled receiver holds the current pixel; the set
// queue then fills and s_axis_tready falls until pixels drain.
module midpoint_circle_generator
    import mcg_pkg::*;
#(
    parameter int COORD_BITS = 11
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // center_x, center_y, radius, half_mode, zero fill
    input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // opcode
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // pixel_x, pixel_y, zero fill
    output logic [((2*(COORD_BITS+1)+7)/8)*8-1:0] m_axis_tdata,
    // set_end
    output logic                   m_axis_tlast,
    // circle_end
    output logic                   m_axis_tuser
);

    localparam int C           = COORD_BITS;
    localparam int OUT_TDATA_W = ((2*(C+1)+7)/8)*8;
    localparam int CY_LO       = C;
    localparam int R_LO        = 2*C;
    localparam int HALF_BIT    = 3*C - 1;

    logic                  w_accept, w_push, w_full, w_q_valid, w_pop;
    logic signed [C-1:0]   w_in_cx, w_in_cy;
    logic        [C-2:0]   w_in_r;
    logic signed [C-1:0]   w_f_cx, w_f_cy, w_f_x, w_f_y;
    logic signed [C-1:0]   w_q_cx, w_q_cy, w_q_x, w_q_y;
    t_job_ctl              w_f_ctl, w_q_ctl;
    logic signed [C:0]     w_px, w_py;

    // input field unpacking
    assign w_in_cx = s_axis_tdata[C-1:0];
    assign w_in_cy = s_axis_tdata[CY_LO+C-1:CY_LO];
    assign w_in_r  = s_axis_tdata[R_LO+C-2:R_LO];

    // the front accepts whenever the set queue has room
    assign s_axis_tready = !w_full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    mcg_front #(.COORD_BITS(C)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_opcode    (s_axis_tuser),
        .i_center_x  (w_in_cx),
        .i_center_y  (w_in_cy),
        .i_radius    (w_in_r),
        .i_half_mode (s_axis_tdata[HALF_BIT]),
        .o_push      (w_push),
        .o_cx        (w_f_cx),
        .o_cy        (w_f_cy),
        .o_x         (w_f_x),
        .o_y         (w_f_y),
        .o_ctl       (w_f_ctl)
    );

    mcg_queue #(.COORD_BITS(C)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cx    (w_f_cx),
        .i_cy    (w_f_cy),
        .i_x     (w_f_x),
        .i_y     (w_f_y),
        .i_ctl   (w_f_ctl),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cx    (w_q_cx),
        .o_cy    (w_q_cy),
        .o_x     (w_q_x),
        .o_y     (w_q_y),
        .o_ctl   (w_q_ctl)
    );

    mcg_back #(.COORD_BITS(C)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_q_valid),
        .i_cx         (w_q_cx),
        .i_cy         (w_q_cy),
        .i_x          (w_q_x),
        .i_y          (w_q_y),
        .i_ctl        (w_q_ctl),
        .o_pop        (w_pop),
        .i_tready     (m_axis_tready),
        .o_tvalid     (m_axis_tvalid),
        .o_pixel_x    (w_px),
        .o_pixel_y    (w_py),
        .o_set_end    (m_axis_tlast),
        .o_circle_end (m_axis_tuser)
    );

    // output packing, zero filled to whole bytes
    assign m_axis_tdata = OUT_TDATA_W'({w_py, w_px});

endmodule
